// ===== hw/rtl/sbef_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbef_pkg
// Shared types, register indexes and Q31 arithmetic helpers for the stereo
// biquad with truncation error feedback.
// ----------------------------------------------------------------------------
package sbef_pkg;

    localparam int DATA_W     = 32;
    localparam int ACC_W      = 64;
    localparam int REM_W      = 31;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

    localparam logic [ACC_W-1:0]  SMAX64   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0]  SMIN64   = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] Q31_NEG1 = 32'h8000_0000;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic [ACC_W-1:0]         acc_t;
    typedef logic [REM_W-1:0]         rem_t;

    // Coefficient set shared by both channels, each value is half the true one.
    typedef struct packed {
        sample_t b0;
        sample_t b1;
        sample_t b2;
        sample_t a1;
        sample_t a2;
    } coef_t;

    // Fractional Q31 x Q31 product in Q63; (-1) x (-1) clamps to the maximum.
    function automatic acc_t frac_mul(input sample_t a, input sample_t b);
        logic signed [ACC_W-1:0] p;
        p = ACC_W'(a) * ACC_W'(b);
        if (a == Q31_NEG1 && b == Q31_NEG1)
            return SMAX64;
        return {p[ACC_W-2:0], 1'b0};
    endfunction

    function automatic acc_t sat_add(input acc_t a, input acc_t b);
        acc_t s;
        s = a + b;
        if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1])
            return a[ACC_W-1] ? SMIN64 : SMAX64;
        return s;
    endfunction

    function automatic acc_t sat_sub(input acc_t a, input acc_t b);
        acc_t s;
        s = a - b;
        if (a[ACC_W-1] != b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1])
            return a[ACC_W-1] ? SMIN64 : SMAX64;
        return s;
    endfunction

    function automatic acc_t sat_shl1(input acc_t a);
        if (a[ACC_W-1:ACC_W-2] == 2'b01)
            return SMAX64;
        if (a[ACC_W-1:ACC_W-2] == 2'b10)
            return SMIN64;
        return {a[ACC_W-2:0], 1'b0};
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sbef_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbef_cfg_regs
// APB-style register file for the five halved biquad coefficients.
// ----------------------------------------------------------------------------
module sbef_cfg_regs
    import sbef_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic      [DATA_W-1:0]     prdata,
    output logic                       pready,
    output coef_t                      coef
);

    coef_t                coef_reg;
    coef_t                coef_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign coef    = coef_reg;

    always_comb
    begin
        coef_next = coef_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_B0:  coef_next.b0 = pwdata;
                REG_B1:  coef_next.b1 = pwdata;
                REG_B2:  coef_next.b2 = pwdata;
                REG_A1:  coef_next.a1 = pwdata;
                REG_A2:  coef_next.a2 = pwdata;
                default: coef_next = coef_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_B0:  prdata = coef_reg.b0;
            REG_B1:  prdata = coef_reg.b1;
            REG_B2:  prdata = coef_reg.b2;
            REG_A1:  prdata = coef_reg.a1;
            REG_A2:  prdata = coef_reg.a2;
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_reg <= '0;
        else
            coef_reg <= coef_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/sbef_channel.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbef_channel
// One channel of the direct form I biquad: delay line, remainder and the
// saturating five-term accumulation done in a single pass.
// ----------------------------------------------------------------------------
module sbef_channel
    import sbef_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire sample_t x,
    input  wire coef_t   coef,
    output sample_t      y
);

    sample_t x1_reg, x2_reg, y1_reg, y2_reg;
    rem_t    rem_reg;
    acc_t    p_b0, p_a1, p_b1, p_a2, p_b2;
    acc_t    acc0, acc1, acc2, acc3, acc4, acc5;
    acc_t    shifted;

    // The five products are independent; only the accumulation is ordered.
    assign p_b0 = frac_mul(coef.b0, x);
    assign p_a1 = frac_mul(coef.a1, y1_reg);
    assign p_b1 = frac_mul(coef.b1, x1_reg);
    assign p_a2 = frac_mul(coef.a2, y2_reg);
    assign p_b2 = frac_mul(coef.b2, x2_reg);

    always_comb
    begin
        acc0    = {{(ACC_W-REM_W){1'b0}}, rem_reg};
        acc1    = sat_add(acc0, p_b0);
        acc2    = sat_sub(acc1, p_a1);
        acc3    = sat_add(acc2, p_b1);
        acc4    = sat_sub(acc3, p_a2);
        acc5    = sat_add(acc4, p_b2);
        shifted = sat_shl1(acc5);
        y       = shifted[ACC_W-1:ACC_W-DATA_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg  <= '0;
            x2_reg  <= '0;
            y1_reg  <= '0;
            y2_reg  <= '0;
            rem_reg <= '0;
        end
        else if (en)
        begin
            x1_reg  <= x;
            x2_reg  <= x1_reg;
            y1_reg  <= y;
            y2_reg  <= y1_reg;
            // The remainder is taken before the output shift and its clamp.
            rem_reg <= acc5[REM_W-1:0];
        end
    end

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(x1_reg) && $stable(y1_reg) && $stable(rem_reg))
        else $error("channel state changed without a sample");

endmodule
`default_nettype wire

// ===== hw/rtl/stereo_biquad_error_feedback.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_biquad_error_feedback
// Stereo Q31 direct form I biquad with truncation error feedback.
//
//   Channel  Handshake            Beat contents
//   input    in_valid / in_stall  left_in, right_in
//   output   out_valid/ out_stall left_out, right_out
//   config   APB (psel..pready)   b0/b1/b2/a1/a2 halves at 0x00..0x10
//
// A beat is latched in the input register, filtered combinationally and
// held in the output register; one beat is taken every cycle unless an
// output stall backs up. The feedback path from the previous output through
// the a1 product and the saturating accumulate chain sets the clock period.
// Reset clears coefficients, delay lines and remainders to zero. An output
// stall holds the result and backs up into in_stall once the input register
// is also full.
// ----------------------------------------------------------------------------
module stereo_biquad_error_feedback
    import sbef_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire sample_t               left_in,
    input  wire sample_t               right_in,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output sample_t                    left_out,
    output sample_t                    right_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic      [DATA_W-1:0]     prdata,
    output logic                       pready
);

    coef_t   coef;
    logic    s1_valid_reg, s1_valid_next;
    sample_t left_s1_reg, right_s1_reg;
    logic    out_valid_reg, out_valid_next;
    sample_t left_out_reg, right_out_reg;
    sample_t left_y, right_y;
    logic    advance;
    logic    in_accept;

    sbef_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    sbef_channel u_left (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .x     (left_s1_reg),
        .coef  (coef),
        .y     (left_y)
    );

    sbef_channel u_right (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .x     (right_s1_reg),
        .coef  (coef),
        .y     (right_y)
    );

    // A beat moves on when the output register is empty or being drained.
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    always_comb
    begin
        s1_valid_next  = in_accept || (s1_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            left_s1_reg  <= left_in;
            right_s1_reg <= right_in;
        end
        if (advance)
        begin
            left_out_reg  <= left_y;
            right_out_reg <= right_y;
        end
    end

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && out_stall |-> in_stall)
        else $error("input taken while both stages are blocked");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("filtered beat did not reach the output register");

    a_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(left_s1_reg))
        else $error("waiting input beat was lost");

endmodule
`default_nettype wire
